// ===== rtl/core/gemm_tile_outer_product_accumulate_macros.svh =====
// Assertion macros for the tile outer-product accumulator.
// Define ASSERT_OFF to drop all checks.
`ifndef GEMM_TILE_OUTER_PRODUCT_ACCUMULATE_MACROS_SVH
`define GEMM_TILE_OUTER_PRODUCT_ACCUMULATE_MACROS_SVH

`ifndef ASSERT_OFF
`define GTOPA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GTOPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GTOPA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define GTOPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/gtopa_pkg.sv =====
package gtopa_pkg;

  localparam int LANE_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  // counts up to the largest tile side (16) and the 4-bit column register
  localparam int CNT_W  = 5;

  localparam int DEF_TILE_ROWS = 6;
  localparam int DEF_TILE_COLS = 8;

  localparam int ROWS_W = 3;
  localparam int COLS_W = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd6;
  localparam logic [COLS_W-1:0] COLS_RESET = 4'd8;

  // configuration register indexes
  localparam logic REG_ACTIVE_ROWS = 1'b0;
  localparam logic REG_ACTIVE_COLS = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic mul_en;    // register this step's product
    logic acc_en;    // add the registered product
    logic shift_en;  // take the neighbour's accumulator
  } cell_ctl_t;

endpackage

// ===== rtl/core/gtopa_cell.sv =====
module gtopa_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  gtopa_pkg::cell_ctl_t                ctl,
  input  logic signed [gtopa_pkg::LANE_W-1:0] a,
  input  logic signed [gtopa_pkg::LANE_W-1:0] b,
  input  logic signed [gtopa_pkg::ACC_W-1:0]  shift_in,
  output logic signed [gtopa_pkg::ACC_W-1:0]  acc
);
  import gtopa_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  acc_next;

  // product stage, payload only
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

  assign sum = (ACC_W+1)'(acc) + (ACC_W+1)'(prod);

  always_comb begin
    acc_next = acc;
    if (ctl.shift_en) begin
      acc_next = shift_in;
    end else if (ctl.acc_en) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_next = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

// ===== rtl/core/gemm_tile_outer_product_accumulate.sv =====
// Tile outer-product accumulator. Each step item carries one column of A and
// one row of B (signed Q1.14 lanes) and adds their outer product into a
// TILE_ROWS x TILE_COLS set of 48-bit saturating Q19.28 accumulators, one per
// cell of a chain of MAC cells. Ordinary steps are taken one per cycle
// while step_stall is low: a multiply stage then an accumulate stage in
// every cell. A step with last_step set is followed by a drain: the chain
// shifts one place a cycle towards cell (0,0), whose value goes to the
// result register, so the drain always walks all TILE_ROWS*TILE_COLS cells
// and waits while the result side stalls; only the active_rows x active_cols
// corner is emitted, in row order, and zeros shifted in at the far end leave
// the tile cleared. step_stall is high while a last step is in the product
// stage and for the whole drain. active_rows/active_cols above the tile size
// are clamped; a zero in either gives no results but still clears the tile.
module gemm_tile_outer_product_accumulate #(
  parameter int TILE_ROWS = gtopa_pkg::DEF_TILE_ROWS,
  parameter int TILE_COLS = gtopa_pkg::DEF_TILE_COLS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write,
  input  logic                                   cfg_index,
  input  logic [gtopa_pkg::CFG_DATA_W-1:0]       cfg_data,
  // step items
  input  logic                                   step_valid,
  output logic                                   step_stall,
  input  logic [63:0]                            a_rows_0_3,
  input  logic [31:0]                            a_rows_4_5,
  input  logic [63:0]                            b_cols_0_3,
  input  logic [63:0]                            b_cols_4_7,
  input  logic                                   last_step,
  // result items
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [2:0]                             row,
  output logic [2:0]                             column,
  output logic signed [gtopa_pkg::ACC_W-1:0]     value,
  output logic                                   last
);
  import gtopa_pkg::*;

  `include "gemm_tile_outer_product_accumulate_macros.svh"

  localparam int CELLS = TILE_ROWS * TILE_COLS;
  localparam int RCW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int CCW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state, state_next;

  logic [ROWS_W-1:0] active_rows;
  logic [COLS_W-1:0] active_cols;

  logic step_accept;
  logic p_valid, p_last;   // product stage occupancy
  logic shift;
  logic drain_end;
  logic in_region, elem_last;

  logic [RCW-1:0] r_cnt;
  logic [CCW-1:0] c_cnt;
  logic [CNT_W-1:0] r_ext, c_ext, nr, nc;

  logic signed [LANE_W-1:0] a_lane [TILE_ROWS];
  logic signed [LANE_W-1:0] b_lane [TILE_COLS];
  logic signed [ACC_W-1:0]  chain  [CELLS+1];
  cell_ctl_t ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= ROWS_RESET;
      active_cols <= COLS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_ROWS: active_rows <= cfg_data[ROWS_W-1:0];
        REG_ACTIVE_COLS: active_cols <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // operand lanes; rows/columns with no input lane read as zero
  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_a
    if (r < 4) begin : g_lo
      assign a_lane[r] = a_rows_0_3[LANE_W*r +: LANE_W];
    end else if (r < 6) begin : g_hi
      assign a_lane[r] = a_rows_4_5[LANE_W*(r-4) +: LANE_W];
    end else begin : g_none
      assign a_lane[r] = '0;
    end
  end

  for (genvar c = 0; c < TILE_COLS; c++) begin : g_b
    if (c < 4) begin : g_lo
      assign b_lane[c] = b_cols_0_3[LANE_W*c +: LANE_W];
    end else if (c < 8) begin : g_hi
      assign b_lane[c] = b_cols_4_7[LANE_W*(c-4) +: LANE_W];
    end else begin : g_none
      assign b_lane[c] = '0;
    end
  end

  // hold off new steps while a last step is in the product stage or draining
  assign step_stall  = (state == ST_DRAIN) || (p_valid && p_last);
  assign step_accept = step_valid && !step_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last  <= 1'b0;
    end else begin
      p_valid <= step_accept;
      p_last  <= step_accept && last_step;
    end
  end

  // drain advances only when the result register is free or being emptied
  assign shift = (state == ST_DRAIN) && (!result_valid || !result_stall);
  assign drain_end = shift && (r_cnt == RCW'(TILE_ROWS - 1))
                     && (c_cnt == CCW'(TILE_COLS - 1));

  assign ctl.mul_en   = step_accept;
  assign ctl.acc_en   = p_valid;
  assign ctl.shift_en = shift;

  // the chain: cell k takes cell k+1, the far end takes zero
  assign chain[CELLS] = '0;
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    gtopa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .a        (a_lane[k / TILE_COLS]),
      .b        (b_lane[k % TILE_COLS]),
      .shift_in (chain[k+1]),
      .acc      (chain[k])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:   if (p_valid && p_last) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_end) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // position of the element now at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else if (state == ST_RUN) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else if (shift) begin
      if (c_cnt == CCW'(TILE_COLS - 1)) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + RCW'(1);
      end else begin
        c_cnt <= c_cnt + CCW'(1);
      end
    end
  end

  assign r_ext = CNT_W'(r_cnt);
  assign c_ext = CNT_W'(c_cnt);
  assign nr = (CNT_W'(active_rows) > CNT_W'(TILE_ROWS)) ? CNT_W'(TILE_ROWS)
                                                         : CNT_W'(active_rows);
  assign nc = (CNT_W'(active_cols) > CNT_W'(TILE_COLS)) ? CNT_W'(TILE_COLS)
                                                         : CNT_W'(active_cols);
  assign in_region = (r_ext < nr) && (c_ext < nc);
  assign elem_last = (r_ext == nr - CNT_W'(1)) && (c_ext == nc - CNT_W'(1));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (shift && in_region) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift && in_region) begin
      row    <= r_ext[2:0];
      column <= c_ext[2:0];
      value  <= chain[0];
      last   <= elem_last;
    end
  end

  `GTOPA_ASSERT_SAME(a_no_step_in_drain, clk, rst, state == ST_DRAIN, !step_accept, "step accepted during drain")
  `GTOPA_ASSERT_SAME(a_no_overwrite, clk, rst, shift && in_region, !result_valid || !result_stall, "result overwritten while stalled")
  `GTOPA_ASSERT_NEXT(a_tile_cleared, clk, rst, drain_end, chain[0] == '0 && state == ST_RUN, "tile not cleared after drain")
  `GTOPA_ASSERT_SAME(a_no_acc_in_drain, clk, rst, state == ST_DRAIN, !p_valid, "accumulate during drain")

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gtopa_pkg::*;

  localparam int ROWS = DEF_TILE_ROWS;
  localparam int COLS = DEF_TILE_COLS;
  localparam int CELLS = ROWS * COLS;
  // the drain walks every cell once; settle past a full drain before touching registers
  localparam int SETTLE_CYCLES = 2 * CELLS + 8;
  localparam int PHASE_STEPS = 34;
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam longint ACC_TOP = longint'(ACC_MAX);
  localparam longint ACC_BOTTOM = longint'(ACC_MIN);

  // one depth step: a column of A, a row of B, and the end-of-tile mark
  typedef struct {
    logic [63:0] a03;
    logic [31:0] a45;
    logic [63:0] b03;
    logic [63:0] b47;
    logic        last_step;
  } step_t;

  // one emitted tile element
  typedef struct {
    logic [2:0]              row;
    logic [2:0]              column;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } element_t;

  // ---------------------------------------------------------------------------
  // Block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic                    cfg_index = REG_ACTIVE_ROWS;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    step_valid = 1'b0;
  logic                    step_stall;
  logic [63:0]             a_rows_0_3 = '0;
  logic [31:0]             a_rows_4_5 = '0;
  logic [63:0]             b_cols_0_3 = '0;
  logic [63:0]             b_cols_4_7 = '0;
  logic                    last_step = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [2:0]              row;
  logic [2:0]              column;
  logic signed [ACC_W-1:0] value;
  logic                    last;

  gemm_tile_outer_product_accumulate DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step_valid   (step_valid),
    .step_stall   (step_stall),
    .a_rows_0_3   (a_rows_0_3),
    .a_rows_4_5   (a_rows_4_5),
    .b_cols_0_3   (b_cols_0_3),
    .b_cols_4_7   (b_cols_4_7),
    .last_step    (last_step),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row          (row),
    .column       (column),
    .value        (value),
    .last         (last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted tile state: its own accumulators and register copies
  // ---------------------------------------------------------------------------
  longint                tile_acc [ROWS][COLS];
  logic [ROWS_W-1:0]     rows_setting = ROWS_RESET;
  logic [COLS_W-1:0]     cols_setting = COLS_RESET;

  step_t    steps_pending [$];   // items not yet offered to the block
  element_t elements_due [$];    // tile elements still to come out, oldest first
  step_t    on_port;             // item currently on the step port
  element_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int steps_taken = 0;
  int tiles_closed = 0;
  int elements_checked = 0;
  int reg_writes = 0;

  initial begin
    foreach (tile_acc[r, c]) tile_acc[r][c] = 0;
  end

  // signed Q1.14 lane, sign-extended
  function automatic longint lane(logic [63:0] word, int idx);
    return longint'($signed(word[16*idx +: 16]));
  endfunction

  // Add one outer product into the tile, saturating each cell; on the last
  // step queue the active corner in row order and clear the tile.
  function automatic void accumulate_step(step_t s);
    longint av, bv, total;
    int nr, nc;
    element_t e;
    for (int r = 0; r < ROWS; r++) begin
      av = (r < 4) ? lane(s.a03, r) : lane({32'd0, s.a45}, r - 4);
      for (int c = 0; c < COLS; c++) begin
        bv = (c < 4) ? lane(s.b03, c) : lane(s.b47, c - 4);
        total = tile_acc[r][c] + av * bv;
        if (total > ACC_TOP) total = ACC_TOP;
        else if (total < ACC_BOTTOM) total = ACC_BOTTOM;
        tile_acc[r][c] = total;
      end
    end
    if (!s.last_step) return;
    // oversized counts clamp to the tile; a zero gives an empty corner
    nr = (rows_setting > ROWS) ? ROWS : int'(rows_setting);
    nc = (cols_setting > COLS) ? COLS : int'(cols_setting);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        e.row = 3'(r);
        e.column = 3'(c);
        e.value = ACC_W'(tile_acc[r][c]);
        e.last = (r == nr - 1) && (c == nc - 1);
        elements_due.push_back(e);
      end
    end
    foreach (tile_acc[r, c]) tile_acc[r][c] = 0;
    tiles_closed++;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending items, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else begin
      if (step_valid && !step_stall) begin
        accumulate_step(on_port);
        steps_taken++;
      end
      // payload held while stalled; a fresh item only once the port is free
      if (!step_valid || !step_stall) begin
        if (steps_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port = steps_pending.pop_front();
          a_rows_0_3 <= on_port.a03;
          a_rows_4_5 <= on_port.a45;
          b_cols_0_3 <= on_port.b03;
          b_cols_4_7 <= on_port.b47;
          last_step <= on_port.last_step;
          step_valid <= 1'b1;
        end else begin
          step_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, each accepted element against the oldest
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (elements_due.size() == 0) begin
        $display("%0t: unexpected element, expected none, got row %0d column %0d value %h",
                 $time, row, column, value);
        mismatches++;
      end else begin
        want = elements_due.pop_front();
        check_field("row", 64'(want.row), 64'(row));
        check_field("column", 64'(want.column), 64'(column));
        check_field("value", 64'(want.value), 64'(value));
        check_field("last", 64'(want.last), 64'(last));
        elements_checked++;
      end
    end
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // lanes lean towards the extremes of Q1.14 and the all-ones pattern
  function automatic logic [15:0] pick_lane();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic step_t random_step(logic is_last);
    step_t s;
    for (int l = 0; l < 4; l++) begin
      s.a03[16*l +: 16] = pick_lane();
      s.b03[16*l +: 16] = pick_lane();
      s.b47[16*l +: 16] = pick_lane();
    end
    for (int l = 0; l < 2; l++) s.a45[16*l +: 16] = pick_lane();
    s.last_step = is_last;
    return s;
  endfunction

  // every A lane one value, every B lane another
  function automatic step_t flat_step(logic [15:0] a, logic [15:0] b, logic is_last);
    step_t s;
    s.a03 = {4{a}};
    s.a45 = {2{a}};
    s.b03 = {4{b}};
    s.b47 = {4{b}};
    s.last_step = is_last;
    return s;
  endfunction

  function automatic int push_tile(int depth);
    for (int i = 0; i < depth; i++) steps_pending.push_back(random_step(i == depth - 1));
    return depth;
  endfunction

  // register write; the copy follows at once since the block is idle
  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_ACTIVE_ROWS) rows_setting = data[ROWS_W-1:0];
    else cols_setting = data[COLS_W-1:0];
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_tile(logic [CFG_DATA_W-1:0] rows_data, logic [CFG_DATA_W-1:0] cols_data);
    write_reg(REG_ACTIVE_ROWS, rows_data);
    write_reg(REG_ACTIVE_COLS, cols_data);
  endtask

  // Wait until every item is in and every element out, then let the drain
  // finish unstalled: it keeps walking cells after the last element.
  task automatic wait_idle();
    do @(posedge clk);
    while (steps_pending.size() != 0 || step_valid || elements_due.size() != 0);
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // two register settings per phase, tiles of mostly short depth
  task automatic run_phase(int send_pct, int recv_pct);
    int queued;
    for (int half = 0; half < 2; half++) begin
      set_tile(4'($urandom_range(15)), 4'($urandom_range(15)));
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      queued = 0;
      while (queued < PHASE_STEPS / 2)
        queued += push_tile(($urandom_range(9) == 0) ? $urandom_range(7, 20)
                                                     : $urandom_range(1, 4));
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    step_t s;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Full 6x8 tile at reset settings: largest positive and negative products
    steps_pending.push_back(flat_step(16'h7FFF, 16'h7FFF, 1'b0));
    steps_pending.push_back(flat_step(16'h8000, 16'h8000, 1'b0));
    steps_pending.push_back(flat_step(16'h8000, 16'h7FFF, 1'b1));
    // distinct value in every lane, so a swapped lane shows in its own cell
    for (int l = 0; l < 4; l++) begin
      s.a03[16*l +: 16] = 16'((l + 1) * 257);
      s.b03[16*l +: 16] = 16'((l + 1) * ((l % 2) ? -37 : 41));
      s.b47[16*l +: 16] = 16'((l + 5) * ((l % 2) ? -37 : 41));
    end
    s.a45 = {16'(-6 * 257), 16'(5 * 257)};
    s.last_step = 1'b1;
    steps_pending.push_back(s);
    // all-ones lanes, then an all-zero closing step
    steps_pending.push_back(flat_step(16'hFFFF, 16'hFFFF, 1'b0));
    steps_pending.push_back(flat_step(16'h0000, 16'h0000, 1'b1));
    wait_idle();

    // Edge tiles: zero rows, zero columns (tile still cleared), oversized
    // counts clamped, single element, and a ragged corner
    set_tile(4'd0, 4'd8);
    void'(push_tile(2));
    wait_idle();
    set_tile(4'd6, 4'd0);
    void'(push_tile(2));
    wait_idle();
    set_tile(4'd7, 4'd15);
    void'(push_tile(2));
    wait_idle();
    set_tile(4'd1, 4'd1);
    void'(push_tile(2));
    wait_idle();
    set_tile(4'd5, 4'd3);
    void'(push_tile(2));
    wait_idle();

    // Random tiles under each handshake pressure mode
    run_phase(0, 0);
    run_phase(64, 0);
    run_phase(0, 64);
    run_phase(9, 9);

    $display("Checked %0d tile elements from %0d steps in %0d tiles across %0d register writes.",
             elements_checked, steps_taken, tiles_closed, reg_writes);
    $display("Covered full-scale lanes, edge and clamped tiles and all four pressure modes.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
